>>> src/fbc64_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and round helpers for the 64-bit feistel cipher
package fbc64_pkg;

	localparam int unsigned HalfW = 32;
	localparam int unsigned CntW  = 8;

	localparam logic OP_ENC = 1'b0;
	localparam logic OP_DEC = 1'b1;

	typedef struct packed {
		logic load;
		logic step;
		logic emit;
	} fbc64_cmd_t;

	typedef struct packed {
		logic last;
	} fbc64_stat_t;

	// rotate right by whole bytes
	function automatic logic [HalfW-1:0] rotr_bytes(input logic [HalfW-1:0] v,
		input logic [1:0] b);
		logic [HalfW-1:0] r;
		unique case (b)
			2'd0: r = v;
			2'd1: r = {v[7:0], v[31:8]};
			2'd2: r = {v[15:0], v[31:16]};
			2'd3: r = {v[23:0], v[31:24]};
			default: r = v;
		endcase
		return r;
	endfunction

	// n*(n-1)/2 mod 4, which depends only on n mod 8
	function automatic logic [1:0] tri_mod4(input logic [2:0] n);
		logic [1:0] r;
		unique case (n)
			3'd0: r = 2'd0;
			3'd1: r = 2'd0;
			3'd2: r = 2'd1;
			3'd3: r = 2'd3;
			3'd4: r = 2'd2;
			3'd5: r = 2'd2;
			3'd6: r = 2'd3;
			3'd7: r = 2'd1;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	// round function: rotl(h,9) ^ ~(rotr(k,11) ^ h)
	function automatic logic [HalfW-1:0] round_f(input logic [HalfW-1:0] h,
		input logic [HalfW-1:0] k);
		return {h[22:0], h[31:23]} ^ ~({k[10:0], k[31:11]} ^ h);
	endfunction

endpackage

>>> src/fbc64_dp.sv
`timescale 1ns / 1ps
// datapath: working halves, key schedule, round counter and result register
module fbc64_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  fbc64_pkg::fbc64_cmd_t      cmd,
	output fbc64_pkg::fbc64_stat_t     stat,
	input  logic                       opcode,
	input  logic [63:0]                block_in,
	input  logic [31:0]                base_key,
	input  logic [7:0]                 rounds,
	output logic [63:0]                block_out
);
	import fbc64_pkg::*;

	logic [HalfW-1:0] l_q, r_q, k_q;
	logic [CntW-1:0]  cnt_q, n_q;
	logic             dec_q;
	logic [63:0]      out_q;

	logic [CntW-1:0]  diff;
	logic [1:0]       rot_amt;
	logic [HalfW-1:0] k_use;
	logic [HalfW-1:0] f_out;

	always_comb begin
		diff    = cnt_q - n_q;
		rot_amt = (dec_q == OP_DEC) ? diff[1:0] : cnt_q[1:0];
		k_use   = (cnt_q == '0) ? k_q : rotr_bytes(k_q, rot_amt);
		f_out   = round_f((dec_q == OP_DEC) ? r_q : l_q, k_use);
	end

	assign stat.last = (cnt_q == n_q);
	assign block_out = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			n_q   <= '0;
			dec_q <= OP_ENC;
		end else if (cmd.load) begin
			cnt_q <= '0;
			n_q   <= rounds;
			dec_q <= opcode;
		end else if (cmd.step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			l_q <= block_in[63:32];
			r_q <= block_in[31:0];
			k_q <= (opcode == OP_DEC) ? rotr_bytes(base_key, tri_mod4(rounds[2:0])) : base_key;
		end else if (cmd.step) begin
			k_q <= k_use;
			if (dec_q == OP_DEC) begin
				l_q <= r_q;
				r_q <= l_q ^ f_out;
			end else begin
				l_q <= r_q ^ f_out;
				r_q <= l_q;
			end
		end
		if (cmd.emit) begin
			out_q <= {l_q, r_q};
		end
	end

endmodule

>>> src/fbc64_ctrl.sv
`timescale 1ns / 1ps
// controller: request intake, round sequencing and result handshake
module fbc64_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	output logic                       out_valid,
	input  logic                       out_ready,
	input  fbc64_pkg::fbc64_stat_t     stat,
	output fbc64_pkg::fbc64_cmd_t      cmd
);
	import fbc64_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic state_q, state_d;
	logic out_valid_q;
	logic out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.step = 1'b0;
		cmd.emit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_RUN;
				end
			end
			ST_RUN: begin
				if (!stat.last) begin
					cmd.step = 1'b1;
				end else if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> src/feistel_block_cipher_64_unit.sv
`timescale 1ns / 1ps
// top level of the 64-bit feistel block cipher with its register port
// Encrypts or decrypts one 64-bit block per request with a Feistel network on
// two 32-bit halves, one round per clock in a shared round unit. A request
// occupies the unit for the load at acceptance, n rounds, n being round_count
// saturated at MAX_ROUNDS, and a step that registers the result, which waits
// while an earlier result is still held without out_ready. The next request is
// taken the cycle after the result is registered, even while that result
// still waits on out_ready. Registers: base_key at 0x0, round_count at 0x4;
// write them only while the block is idle.
module feistel_block_cipher_64_unit #(
	parameter int unsigned MAX_ROUNDS = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [63:0] block_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] block_out
);
	import fbc64_pkg::*;

	localparam logic REG_BASE_KEY = 1'b0;
	localparam logic REG_ROUNDS   = 1'b1;
	localparam logic [7:0] MaxR   = 8'(MAX_ROUNDS);

	logic [31:0]  base_key_q;
	logic [7:0]   round_count_q;
	logic [7:0]   rounds;
	logic         wr_en;
	fbc64_cmd_t   cmd;
	fbc64_stat_t  stat;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign rounds = (round_count_q > MaxR) ? MaxR : round_count_q;

	always_comb begin
		unique case (paddr[2])
			REG_BASE_KEY: prdata = base_key_q;
			REG_ROUNDS:   prdata = {24'd0, round_count_q};
			default:      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_key_q    <= '0;
			round_count_q <= 8'd99;
		end else if (wr_en) begin
			if (paddr[2] == REG_BASE_KEY) begin
				base_key_q <= pwdata;
			end else begin
				round_count_q <= pwdata[7:0];
			end
		end
	end

	fbc64_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	fbc64_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.opcode    (opcode),
		.block_in  (block_in),
		.base_key  (base_key_q),
		.rounds    (rounds),
		.block_out (block_out)
	);

endmodule

>>> src/fbc64_chk.sv
`timescale 1ns / 1ps
// port-level checker for the feistel cipher top level and its bind
module fbc64_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] block_out
);

	// one request in flight at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	// a result appears only after a request was in progress
	a_result_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result without a running request");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before acceptance");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(block_out))
		else $error("stalled result changed");

endmodule

bind feistel_block_cipher_64_unit fbc64_chk u_fbc64_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.block_out (block_out)
);
